// ===== hdl/flat_bottom_distance_restraint_top_assert.svh =====
// ----------------------------------------------------------------------------
// flat-bottom distance restraint assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef FLAT_BOTTOM_DISTANCE_RESTRAINT_TOP_ASSERT_SVH
`define FLAT_BOTTOM_DISTANCE_RESTRAINT_TOP_ASSERT_SVH

// same-cycle implication under reset
`define FBDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define FBDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fbdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbdr_pkg
// widths, constants and helpers of the flat-bottom distance restraint
// ----------------------------------------------------------------------------
`default_nettype none

package fbdr_pkg;

  localparam int unsigned SLOT_BITS_DEF = 16;
  localparam int unsigned DELTA_W       = 32;
  localparam int unsigned BOUND_W       = 31;
  localparam int unsigned K_W           = 32;
  localparam int unsigned ENERGY_W      = 64;
  localparam int unsigned FORCE_W       = 48;
  localparam int unsigned RAD_W         = 64;   // squared distance
  localparam int unsigned ROOT_W        = 32;   // distance
  localparam int unsigned DMAG_W        = 31;   // |slope excess|
  localparam int unsigned MMAG_W        = 34;   // |energy multiplier|
  localparam int unsigned PM_W          = 63;   // k*|d|
  localparam int unsigned QUO_W         = 63;   // force quotient before shift
  localparam int unsigned NUM_W         = 95;   // |delta|*pm
  localparam int unsigned EPROD_W       = 97;   // pm*|m|
  localparam int unsigned ENERGY_SHIFT  = 37;
  localparam int unsigned FORCE_SHIFT   = 16;
  localparam int unsigned LANES         = 3;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic [ENERGY_W-1:0] ENERGY_LIM = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic [FORCE_W-1:0]  FORCE_MAX  = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0]  FORCE_LIM  = {1'b1, {(FORCE_W-1){1'b0}}};

  function automatic logic [DELTA_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] v);
    abs_delta = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fbdr_if.sv =====
// ----------------------------------------------------------------------------
// fbdr_in_if / fbdr_out_if
// valid/ready channels carrying one restraint and one result
// ----------------------------------------------------------------------------
`default_nettype none

interface fbdr_in_if import fbdr_pkg::*; #(
  parameter int unsigned SlotBits = SLOT_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [DELTA_W-1:0]  delta_x;
  logic signed [DELTA_W-1:0]  delta_y;
  logic signed [DELTA_W-1:0]  delta_z;
  logic [BOUND_W-1:0]         bound_one;
  logic [BOUND_W-1:0]         bound_two;
  logic [BOUND_W-1:0]         bound_three;
  logic [BOUND_W-1:0]         bound_four;
  logic [K_W-1:0]             spring_const;
  logic                       unmapped;
  logic [SlotBits-1:0]        target_slot;
  logic                       last_item;

  modport source (output valid, delta_x, delta_y, delta_z, bound_one, bound_two,
                  bound_three, bound_four, spring_const, unmapped, target_slot,
                  last_item, input ready);
  modport sink   (input valid, delta_x, delta_y, delta_z, bound_one, bound_two,
                  bound_three, bound_four, spring_const, unmapped, target_slot,
                  last_item, output ready);
endinterface

interface fbdr_out_if import fbdr_pkg::*; #(
  parameter int unsigned SlotBits = SLOT_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] energy;
  logic signed [FORCE_W-1:0]  force_x;
  logic signed [FORCE_W-1:0]  force_y;
  logic signed [FORCE_W-1:0]  force_z;
  logic [SlotBits-1:0]        energy_slot;
  logic                       saturated;
  logic                       last_out;

  modport source (output valid, energy, force_x, force_y, force_z, energy_slot,
                  saturated, last_out, input ready);
  modport sink   (input valid, energy, force_x, force_y, force_z, energy_slot,
                  saturated, last_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/flat_bottom_distance_restraint_top.sv =====
// ----------------------------------------------------------------------------
// flat_bottom_distance_restraint_top
// flat-bottom harmonic distance restraint: energy and force per atom pair
// ----------------------------------------------------------------------------
// One restraint beat enters per clock and one result beat leaves per clock
// once the pipe is full and while the output beat is not stalled. The pipe
// holds the 32-stage square root (one root bit per stage), the 63-stage force
// divider (one quotient bit per stage, three axes side by side over a shared
// divisor) and eight register stages for input capture, squaring, summing,
// region select, spring product, partial products, product sums and the
// output register. The whole pipe advances together whenever the output
// register is empty or its beat is taken, so in_i.ready is high exactly then.
// Distance is the floor square root of dx^2+dy^2+dz^2 in Q12.20; energy is
// Q43.20, forces Q27.20, both truncated toward zero and clipped with the
// saturated flag. An unmapped restraint gives the largest positive energy and
// zero forces; zero distance gives zero forces.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_bottom_distance_restraint_top import fbdr_pkg::*; #(
  parameter int unsigned SlotBits = SLOT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbdr_in_if.sink     in_i,
  fbdr_out_if.source  out_o
);

  logic en;

  // --------------------------------------------------------------------------
  // stage 0: capture, magnitudes and signs of the separation vector
  // --------------------------------------------------------------------------
  logic                v0_q;
  logic [DELTA_W-1:0]  a0_q [LANES];
  logic [LANES-1:0]    s0_q;
  logic [BOUND_W-1:0]  b1_0_q, b2_0_q, b3_0_q, b4_0_q;
  logic [K_W-1:0]      k0_q;
  logic                unm0_q, last0_q;
  logic [SlotBits-1:0] slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q[0] <= abs_delta(in_i.delta_x);
      a0_q[1] <= abs_delta(in_i.delta_y);
      a0_q[2] <= abs_delta(in_i.delta_z);
      s0_q    <= {in_i.delta_z[DELTA_W-1], in_i.delta_y[DELTA_W-1],
                  in_i.delta_x[DELTA_W-1]};
      b1_0_q  <= in_i.bound_one;
      b2_0_q  <= in_i.bound_two;
      b3_0_q  <= in_i.bound_three;
      b4_0_q  <= in_i.bound_four;
      k0_q    <= in_i.spring_const;
      unm0_q  <= in_i.unmapped;
      slot0_q <= in_i.target_slot;
      last0_q <= in_i.last_item;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: squares, stage 2: sum of squares
  // --------------------------------------------------------------------------
  localparam int unsigned SideW = LANES*DELTA_W + LANES + 4*BOUND_W + K_W + 1
                                  + SlotBits + 1;

  logic             v1_q, v2_q;
  logic [RAD_W-1:0] sq1_q [LANES];
  logic [RAD_W-1:0] r2_q;
  logic [SideW-1:0] side0, side1_q, side2_q;

  assign side0 = {a0_q[2], a0_q[1], a0_q[0], s0_q, b1_0_q, b2_0_q, b3_0_q, b4_0_q,
                  k0_q, unm0_q, slot0_q, last0_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < LANES; c++) begin
        sq1_q[c] <= {32'b0, a0_q[c]} * {32'b0, a0_q[c]};
      end
      side1_q <= side0;
      // three squares of at most 2^62 each stay below 2^64
      r2_q    <= sq1_q[0] + sq1_q[1] + sq1_q[2];
      side2_q <= side1_q;
    end
  end

  // --------------------------------------------------------------------------
  // square root
  // --------------------------------------------------------------------------
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  logic [SideW-1:0]  side_s;

  fbdr_sqrt #(
    .TagW (SideW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (r2_q),
    .tag_i   (side2_q),
    .valid_o (vs),
    .root_o  (root_s),
    .tag_o   (side_s)
  );

  logic [DELTA_W-1:0]  as [LANES];
  logic [LANES-1:0]    ss;
  logic [BOUND_W-1:0]  b1s, b2s, b3s, b4s;
  logic [K_W-1:0]      ks;
  logic                unms, lasts;
  logic [SlotBits-1:0] slots;

  assign {as[2], as[1], as[0], ss, b1s, b2s, b3s, b4s, ks, unms, slots, lasts} = side_s;

  // --------------------------------------------------------------------------
  // stage 3: region select, slope excess d and energy multiplier m
  // --------------------------------------------------------------------------
  localparam int unsigned SW = ROOT_W + 3;

  logic signed [SW-1:0] rx, e1, e2, e3, e4, d_c, m_c, dabs, mabs;

  always_comb begin
    rx = $signed({3'b000, root_s});
    e1 = $signed({4'b0000, b1s});
    e2 = $signed({4'b0000, b2s});
    e3 = $signed({4'b0000, b3s});
    e4 = $signed({4'b0000, b4s});
    // regions tested in order with strict less-than
    if (rx < e1) begin
      d_c = e1 - e2;
      m_c = (rx <<< 1) - e1 - e2;
    end else if (rx < e2) begin
      d_c = rx - e2;
      m_c = d_c;
    end else if (rx < e3) begin
      d_c = '0;
      m_c = '0;
    end else if (rx < e4) begin
      d_c = rx - e3;
      m_c = d_c;
    end else begin
      d_c = e4 - e3;
      m_c = (rx <<< 1) - e4 - e3;
    end
    dabs = d_c[SW-1] ? -d_c : d_c;
    mabs = m_c[SW-1] ? -m_c : m_c;
  end

  logic                v3_q;
  logic [DMAG_W-1:0]   dm3_q;
  logic [MMAG_W-1:0]   mm3_q;
  logic                dn3_q, mn3_q;
  logic [ROOT_W-1:0]   r3_q;
  logic [DELTA_W-1:0]  a3_q [LANES];
  logic [LANES-1:0]    s3_q;
  logic [K_W-1:0]      k3_q;
  logic                unm3_q, last3_q;
  logic [SlotBits-1:0] slot3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm3_q   <= dabs[DMAG_W-1:0];
      mm3_q   <= mabs[MMAG_W-1:0];
      dn3_q   <= d_c[SW-1];
      mn3_q   <= m_c[SW-1];
      r3_q    <= root_s;
      a3_q    <= as;
      s3_q    <= ss;
      k3_q    <= ks;
      unm3_q  <= unms;
      slot3_q <= slots;
      last3_q <= lasts;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: spring product pm = k*|d| (dE/dr in Q.36)
  // --------------------------------------------------------------------------
  logic                v4_q;
  logic [PM_W-1:0]     pm4_q;
  logic [MMAG_W-1:0]   mm4_q;
  logic                en4_q;
  logic [LANES-1:0]    fn4_q;
  logic                rz4_q;
  logic [ROOT_W-1:0]   r4_q;
  logic [DELTA_W-1:0]  a4_q [LANES];
  logic                unm4_q, last4_q;
  logic [SlotBits-1:0] slot4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm4_q   <= {31'b0, k3_q} * {32'b0, dm3_q};
      mm4_q   <= mm3_q;
      en4_q   <= dn3_q ^ mn3_q;
      fn4_q   <= s3_q ^ {LANES{dn3_q}};
      rz4_q   <= (r3_q == '0);
      r4_q    <= r3_q;
      a4_q    <= a3_q;
      unm4_q  <= unm3_q;
      slot4_q <= slot3_q;
      last4_q <= last3_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: partial products, pm split at bit 32
  // --------------------------------------------------------------------------
  logic                v5_q;
  logic [65:0]         el5_q;
  logic [64:0]         eh5_q;
  logic [63:0]         nl5_q [LANES];
  logic [62:0]         nh5_q [LANES];
  logic                en5_q;
  logic [LANES-1:0]    fn5_q;
  logic                rz5_q;
  logic [ROOT_W-1:0]   r5_q;
  logic                unm5_q, last5_q;
  logic [SlotBits-1:0] slot5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      el5_q <= {34'b0, pm4_q[31:0]} * {32'b0, mm4_q};
      eh5_q <= {34'b0, pm4_q[PM_W-1:32]} * {31'b0, mm4_q};
      for (int c = 0; c < LANES; c++) begin
        nl5_q[c] <= {32'b0, a4_q[c]} * {32'b0, pm4_q[31:0]};
        nh5_q[c] <= {31'b0, a4_q[c]} * {32'b0, pm4_q[PM_W-1:32]};
      end
      en5_q   <= en4_q;
      fn5_q   <= fn4_q;
      rz5_q   <= rz4_q;
      r5_q    <= r4_q;
      unm5_q  <= unm4_q;
      slot5_q <= slot4_q;
      last5_q <= last4_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: product sums, energy finished and clipped here
  // --------------------------------------------------------------------------
  logic [EPROD_W-1:0]  eprod;
  logic [ENERGY_W-1:0] emag, eval;
  logic                esat;
  logic [NUM_W-1:0]    num_c [LANES];

  always_comb begin
    eprod = {31'b0, el5_q} + {eh5_q, 32'b0};
    emag  = {{(ENERGY_W-(EPROD_W-ENERGY_SHIFT)){1'b0}}, eprod[EPROD_W-1:ENERGY_SHIFT]};
    esat  = 1'b0;
    if (en5_q) begin
      if (emag > ENERGY_LIM) begin
        emag = ENERGY_LIM;
        esat = 1'b1;
      end
      eval = -emag;
    end else begin
      if (emag > ENERGY_MAX) begin
        emag = ENERGY_MAX;
        esat = 1'b1;
      end
      eval = emag;
    end
    if (unm5_q) begin
      eval = ENERGY_MAX;
      esat = 1'b0;
    end
    for (int c = 0; c < LANES; c++) begin
      num_c[c] = {31'b0, nl5_q[c]} + {nh5_q[c], 32'b0};
    end
  end

  localparam int unsigned DivTagW = ENERGY_W + 1 + LANES + 1 + 1 + SlotBits + 1;

  logic                v6_q;
  logic [NUM_W-1:0]    num6_q [LANES];
  logic [ROOT_W-1:0]   r6_q;
  logic [DivTagW-1:0]  dtag6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num6_q  <= num_c;
      r6_q    <= r5_q;
      dtag6_q <= {eval, esat, fn5_q, rz5_q, unm5_q, slot5_q, last5_q};
    end
  end

  // --------------------------------------------------------------------------
  // force divider: |delta|*pm / r, later shifted down by 16
  // --------------------------------------------------------------------------
  logic                vd;
  logic [QUO_W-1:0]    quo [LANES];
  logic [DivTagW-1:0]  dtag;

  fbdr_div #(
    .TagW (DivTagW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (r6_q),
    .tag_i   (dtag6_q),
    .valid_o (vd),
    .quo_o   (quo),
    .tag_o   (dtag)
  );

  logic [ENERGY_W-1:0] ed;
  logic                esd, rzd, unmd, lastd;
  logic [LANES-1:0]    fnd;
  logic [SlotBits-1:0] slotd;

  assign {ed, esd, fnd, rzd, unmd, slotd, lastd} = dtag;

  logic [FORCE_W-1:0] fmag [LANES];
  logic [FORCE_W-1:0] fval [LANES];
  logic [LANES-1:0]   fsat;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      fmag[c] = {1'b0, quo[c][QUO_W-1:FORCE_SHIFT]};
      fsat[c] = 1'b0;
      if (fnd[c]) begin
        if (fmag[c] > FORCE_LIM) begin
          fmag[c] = FORCE_LIM;
          fsat[c] = 1'b1;
        end
        fval[c] = -fmag[c];
      end else begin
        if (fmag[c] > FORCE_MAX) begin
          fmag[c] = FORCE_MAX;
          fsat[c] = 1'b1;
        end
        fval[c] = fmag[c];
      end
      // zero distance and unmapped restraints carry no force
      if (rzd || unmd) begin
        fval[c] = '0;
        fsat[c] = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic                out_valid_q;
  logic [ENERGY_W-1:0] energy_q;
  logic [FORCE_W-1:0]  force_q [LANES];
  logic [SlotBits-1:0] slot_q;
  logic                sat_q, last_q;

  assign en = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= ed;
      force_q  <= fval;
      slot_q   <= slotd;
      sat_q    <= esd || (|fsat);
      last_q   <= lastd;
    end
  end

  assign in_i.ready        = en;
  assign out_o.valid       = out_valid_q;
  assign out_o.energy      = energy_q;
  assign out_o.force_x     = force_q[0];
  assign out_o.force_y     = force_q[1];
  assign out_o.force_z     = force_q[2];
  assign out_o.energy_slot = slot_q;
  assign out_o.saturated   = sat_q;
  assign out_o.last_out    = last_q;

endmodule

`default_nettype wire

// ===== hdl/fbdr_sqrt.sv =====
// ----------------------------------------------------------------------------
// fbdr_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module fbdr_sqrt import fbdr_pkg::*; #(
  parameter int unsigned TagW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [TagW-1:0]   tag_o
);

  localparam int unsigned RemW = ROOT_W + 3;

  logic [RemW-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [TagW-1:0]   tag_q  [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [RemW-1:0]   rem_in, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [RAD_W-1:0]  rad_in;
    logic [TagW-1:0]   tag_in;
    logic              vld_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign tag_in  = tag_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in[RemW-3:0], rad_in[RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= {rad_in[RAD_W-3:0], 2'b00};
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hdl/fbdr_div.sv =====
// ----------------------------------------------------------------------------
// fbdr_div
// pipelined restoring divider, three numerators over one shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module fbdr_div import fbdr_pkg::*; #(
  parameter int unsigned TagW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [ROOT_W-1:0] den_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o [LANES],
  output logic [TagW-1:0]   tag_o
);

  // numerator stays below den * 2^QUO_W, so the top part starts below den
  logic [ROOT_W-1:0] rem_q [QUO_W][LANES];
  logic [QUO_W-1:0]  low_q [QUO_W][LANES];
  logic [QUO_W-1:0]  quo_q [QUO_W][LANES];
  logic [ROOT_W-1:0] den_q [QUO_W];
  logic [TagW-1:0]   tag_q [QUO_W];
  logic              vld_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [ROOT_W-1:0] den_in;
    logic [TagW-1:0]   tag_in;
    logic              vld_in;

    if (j == 0) begin : g_first
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
      assign vld_in = vld_q[j-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W-1:0] rem_in, rem_d;
      logic [QUO_W-1:0]  low_in, quo_in, quo_d;
      logic [ROOT_W:0]   rem_sh, diff;

      if (j == 0) begin : g_first
        assign rem_in = num_i[l][NUM_W-1 -: ROOT_W];
        assign low_in = num_i[l][QUO_W-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1][l];
        assign low_in = low_q[j-1][l];
        assign quo_in = quo_q[j-1][l];
      end

      always_comb begin
        rem_sh = {rem_in, low_in[QUO_W-1]};
        diff   = rem_sh - {1'b0, den_in};
        if (rem_sh >= {1'b0, den_in}) begin
          rem_d = diff[ROOT_W-1:0];
          quo_d = {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[ROOT_W-1:0];
          quo_d = {quo_in[QUO_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= rem_d;
          low_q[j][l] <= {low_in[QUO_W-2:0], 1'b0};
          quo_q[j][l] <= quo_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/fbdr_checker.sv =====
// ----------------------------------------------------------------------------
// fbdr_checker
// port-level checks of the restraint block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "flat_bottom_distance_restraint_top_assert.svh"

module fbdr_checker import fbdr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [ENERGY_W-1:0] energy_i,
  input logic [FORCE_W-1:0]  force_x_i,
  input logic [FORCE_W-1:0]  force_y_i,
  input logic [FORCE_W-1:0]  force_z_i,
  input logic                saturated_i
);

  // a stalled result beat stays offered
  `FBDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")

  // an empty output register never blocks the input
  `FBDR_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !out_valid_i, in_ready_i, "input blocked with empty output")

  // the unmapped marker comes with zero forces and no clip
  `FBDR_ASSERT_NOW(a_unmapped, clk_i, rst_ni, out_valid_i && (energy_i == ENERGY_MAX), (force_x_i == '0) && (force_y_i == '0) && (force_z_i == '0) && !saturated_i, "unmapped marker with nonzero force")

  // with these field widths no result can clip
  `FBDR_ASSERT_NOW(a_no_sat, clk_i, rst_ni, out_valid_i, !saturated_i, "unexpected saturation")

endmodule

bind flat_bottom_distance_restraint_top fbdr_checker u_fbdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .energy_i    (out_o.energy),
  .force_x_i   (out_o.force_x),
  .force_y_i   (out_o.force_y),
  .force_z_i   (out_o.force_z),
  .saturated_i (out_o.saturated)
);

`default_nettype wire
